// ----- design/imusfd_pkg.sv -----
// ----------------------------------------------------------------------------
// imusfd_pkg
// Shared types and constants for the IMU serial frame decoder.
// ----------------------------------------------------------------------------
package imusfd_pkg;

  // Frame layout
  localparam int         FRAME_BYTES      = 11;
  localparam logic [7:0] FRAME_HEAD       = 8'h55;
  localparam logic [7:0] TYPE_ACCEL       = 8'h51;
  localparam logic [7:0] TYPE_MAG         = 8'h54;
  localparam logic [3:0] SKIP_AFTER_FRAME = 4'd10;

  // Quantity codes carried on the result channel
  localparam logic [1:0] QTY_ACCEL = 2'd0;
  localparam logic [1:0] QTY_GYRO  = 2'd1;
  localparam logic [1:0] QTY_ANGLE = 2'd2;
  localparam logic [1:0] QTY_MAG   = 2'd3;

  // Configuration register map
  localparam int         CFG_IDX_W      = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_GAIN = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_GAIN  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_GAIN = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAG_GAIN   = 8'd3;

  // Gain reset values
  localparam logic [15:0] ACCEL_GAIN_RST = 16'd16;
  localparam logic [15:0] GYRO_GAIN_RST  = 16'd2000;
  localparam logic [15:0] ANGLE_GAIN_RST = 16'd180;
  localparam logic [15:0] MAG_GAIN_RST   = 16'd32768;

  // Input request: one received byte
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last_in_burst;
  } in_item_t;

  // Result request: one scaled triple
  typedef struct packed {
    logic [1:0]         quantity;
    logic signed [31:0] axis_x;
    logic signed [31:0] axis_y;
    logic signed [31:0] axis_z;
  } out_item_t;

  // Gain register set
  typedef struct packed {
    logic [15:0] accel_gain;
    logic [15:0] gyro_gain;
    logic [15:0] angle_gain;
    logic [15:0] mag_gain;
  } gain_set_t;

  // Raw fields of one accepted frame
  typedef struct packed {
    logic [1:0]  quantity;
    logic [15:0] raw_x;
    logic [15:0] raw_y;
    logic [15:0] raw_z;
  } frame_t;

  // Frame request from the sync stage to the scale stage
  typedef struct packed {
    logic   valid;
    frame_t frame;
  } frame_req_t;

endpackage

// ----- design/imusfd_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// imusfd_cfg_regs
// Gain register bank written through the configuration port.
// ----------------------------------------------------------------------------
module imusfd_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [imusfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                     cfg_data,
  output imusfd_pkg::gain_set_t           gains
);

  imusfd_pkg::gain_set_t gains_r;
  imusfd_pkg::gain_set_t gains_nxt;

  // Writes always taken
  assign cfg_ready = 1'b1;

  // Register decode; unknown indexes leave the bank alone
  always_comb begin
    gains_nxt = gains_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        imusfd_pkg::CFG_ACCEL_GAIN: gains_nxt.accel_gain = cfg_data;
        imusfd_pkg::CFG_GYRO_GAIN:  gains_nxt.gyro_gain  = cfg_data;
        imusfd_pkg::CFG_ANGLE_GAIN: gains_nxt.angle_gain = cfg_data;
        imusfd_pkg::CFG_MAG_GAIN:   gains_nxt.mag_gain   = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r.accel_gain <= imusfd_pkg::ACCEL_GAIN_RST;
      gains_r.gyro_gain  <= imusfd_pkg::GYRO_GAIN_RST;
      gains_r.angle_gain <= imusfd_pkg::ANGLE_GAIN_RST;
      gains_r.mag_gain   <= imusfd_pkg::MAG_GAIN_RST;
    end else begin
      gains_r <= gains_nxt;
    end
  end

  assign gains = gains_r;

endmodule

// ----- design/imusfd_frame_sync.sv -----
// ----------------------------------------------------------------------------
// imusfd_frame_sync
// Byte window, running checksum and frame search; registers matched frames.
// ----------------------------------------------------------------------------
module imusfd_frame_sync (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  imusfd_pkg::in_item_t   in_data,
  output imusfd_pkg::frame_req_t frm_req,
  input  logic                   frm_ready
);

  localparam int NB = imusfd_pkg::FRAME_BYTES;

  logic [7:0] win_r   [NB];
  logic [7:0] win_nxt [NB];
  logic [7:0] sum_r;       // sum of win_r[0..NB-2], mod 256
  logic [7:0] sum_nxt;
  logic [3:0] fill_r;
  logic [3:0] fill_nxt;
  logic [3:0] skip_r;
  logic [3:0] skip_nxt;

  logic                frm_valid_r;
  logic                frm_valid_nxt;
  imusfd_pkg::frame_t  frm_data_r;
  imusfd_pkg::frame_t  frm_data_nxt;

  logic       in_acc;
  logic       slot_free;
  logic       full;
  logic       frame_ok;
  logic       type_hit;
  logic [7:0] type_off;

  // Frame register frees when empty or when the scale stage takes it
  assign slot_free = !frm_valid_r || frm_ready;
  assign in_stall  = !slot_free;
  assign in_acc    = in_valid && slot_free;

  // Window after shifting in the new byte
  always_comb begin
    for (int i = 0; i < NB - 1; i++) begin
      win_nxt[i] = win_r[i+1];
    end
    win_nxt[NB-1] = in_data.rx_byte;
  end

  // Running sum: drop the outgoing oldest byte, add the byte that moves down
  assign sum_nxt  = sum_r - win_r[0] + win_r[NB-1];
  assign fill_nxt = (fill_r < 4'(NB)) ? fill_r + 4'd1 : fill_r;
  assign full     = (fill_nxt == 4'(NB));

  assign frame_ok = full && (skip_r == 4'd0) &&
                    (win_nxt[0] == imusfd_pkg::FRAME_HEAD) &&
                    (sum_nxt == win_nxt[NB-1]);
  assign type_hit = (win_nxt[1] >= imusfd_pkg::TYPE_ACCEL) &&
                    (win_nxt[1] <= imusfd_pkg::TYPE_MAG);
  assign type_off = win_nxt[1] - imusfd_pkg::TYPE_ACCEL;

  // Skip counter: count down after a frame, reload on a new frame
  always_comb begin
    skip_nxt = skip_r;
    if (full && (skip_r != 4'd0)) begin
      skip_nxt = skip_r - 4'd1;
    end else if (frame_ok) begin
      skip_nxt = imusfd_pkg::SKIP_AFTER_FRAME;
    end
  end

  // Raw little-endian fields of the matched frame
  always_comb begin
    frm_data_nxt.quantity = type_off[1:0];
    frm_data_nxt.raw_x    = {win_nxt[3], win_nxt[2]};
    frm_data_nxt.raw_y    = {win_nxt[5], win_nxt[4]};
    frm_data_nxt.raw_z    = {win_nxt[7], win_nxt[6]};
  end

  assign frm_valid_nxt = slot_free ? (in_acc && frame_ok && type_hit) : frm_valid_r;

  // Window, counters and frame valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NB; i++) begin
        win_r[i] <= 8'd0;
      end
      sum_r       <= 8'd0;
      fill_r      <= 4'd0;
      skip_r      <= 4'd0;
      frm_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        if (in_data.last_in_burst) begin
          // burst end drops any partial frame
          for (int i = 0; i < NB; i++) begin
            win_r[i] <= 8'd0;
          end
          sum_r  <= 8'd0;
          fill_r <= 4'd0;
          skip_r <= 4'd0;
        end else begin
          for (int i = 0; i < NB; i++) begin
            win_r[i] <= win_nxt[i];
          end
          sum_r  <= sum_nxt;
          fill_r <= fill_nxt;
          skip_r <= skip_nxt;
        end
      end
      frm_valid_r <= frm_valid_nxt;
    end
  end

  // Frame payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      frm_data_r <= frm_data_nxt;
    end
  end

  assign frm_req.valid = frm_valid_r;
  assign frm_req.frame = frm_data_r;

endmodule

// ----- design/imusfd_scale.sv -----
// ----------------------------------------------------------------------------
// imusfd_scale
// Multiplies the three raw values by the selected gain into the result register.
// ----------------------------------------------------------------------------
module imusfd_scale (
  input  logic                   clk,
  input  logic                   rst_n,
  input  imusfd_pkg::gain_set_t  gains,
  input  imusfd_pkg::frame_req_t frm_req,
  output logic                   frm_ready,
  output logic                   out_valid,
  input  logic                   out_stall,
  output imusfd_pkg::out_item_t  out_data
);

  logic                  out_valid_r;
  imusfd_pkg::out_item_t out_data_r;
  imusfd_pkg::out_item_t out_data_nxt;
  logic [15:0]           gain_sel;
  logic signed [32:0]    prod_x;
  logic signed [32:0]    prod_y;
  logic signed [32:0]    prod_z;

  // Result register frees when empty or taken
  assign frm_ready = !out_valid_r || !out_stall;

  // Gain select by quantity
  always_comb begin
    unique case (frm_req.frame.quantity)
      imusfd_pkg::QTY_ACCEL: gain_sel = gains.accel_gain;
      imusfd_pkg::QTY_GYRO:  gain_sel = gains.gyro_gain;
      imusfd_pkg::QTY_ANGLE: gain_sel = gains.angle_gain;
      imusfd_pkg::QTY_MAG:   gain_sel = gains.mag_gain;
      default:               gain_sel = gains.mag_gain;
    endcase
  end

  // int16 times uint16; product always fits in 32 bits
  assign prod_x = $signed(frm_req.frame.raw_x) * $signed({1'b0, gain_sel});
  assign prod_y = $signed(frm_req.frame.raw_y) * $signed({1'b0, gain_sel});
  assign prod_z = $signed(frm_req.frame.raw_z) * $signed({1'b0, gain_sel});

  always_comb begin
    out_data_nxt.quantity = frm_req.frame.quantity;
    out_data_nxt.axis_x   = prod_x[31:0];
    out_data_nxt.axis_y   = prod_y[31:0];
    out_data_nxt.axis_z   = prod_z[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (frm_ready) begin
      out_valid_r <= frm_req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frm_ready && frm_req.valid) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- design/imu_serial_frame_decoder.sv -----
// ----------------------------------------------------------------------------
// imu_serial_frame_decoder
// Finds checksummed 11-byte IMU frames in a byte stream and scales their axes.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------------
//  in_     | input     | in_valid / in_stall | in_item_t  (rx_byte, last_in_burst)
//  out_    | output    | out_valid/out_stall | out_item_t (quantity, axis_x/y/z)
//  cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data (16-bit gain)
//
//  One byte is accepted per cycle while in_stall is low. A frame's result
//  shows on out_valid after its final byte is accepted: through the frame
//  register, then the gain multiply into the result register.
//  in_stall rises only while a result is held on a stalled output and a
//  second matched frame waits in the frame register.
//  Synchronous reset clears the window, counters, valids and loads the
//  gain defaults; cfg_ready is always high.
//
module imu_serial_frame_decoder (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  imusfd_pkg::in_item_t             in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output imusfd_pkg::out_item_t            out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [imusfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                      cfg_data
);

  imusfd_pkg::gain_set_t  gains;
  imusfd_pkg::frame_req_t frm_req;
  logic                   frm_ready;

  // Gain registers
  imusfd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .gains     (gains)
  );

  // Window and frame search
  imusfd_frame_sync u_sync (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .frm_req   (frm_req),
    .frm_ready (frm_ready)
  );

  // Gain multiply and result register
  imusfd_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .gains     (gains),
    .frm_req   (frm_req),
    .frm_ready (frm_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- design/imusfd_checker.sv -----
// ----------------------------------------------------------------------------
// imusfd_checker
// Port-level checks for the IMU serial frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
module imusfd_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input imusfd_pkg::out_item_t out_data
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Input backs up only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // A fresh result follows an accepted byte through the frame and result registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without a byte two cycles earlier");

  // Reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule

bind imu_serial_frame_decoder imusfd_checker u_chk (.*);
